@@ rtl/aeske_pkg.sv @@
// ----------------------------------------------------------------------------
// AES key expansion package
// Shared types, key size codes, S-box table and schedule helper functions.
// ----------------------------------------------------------------------------
package aeske_pkg;

    localparam int MAX_KEY_WORDS_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] RCON_POLY = 8'h1b;

    localparam logic [5:0] LAST_IDX_128 = 6'd43;
    localparam logic [5:0] LAST_IDX_192 = 6'd51;
    localparam logic [5:0] LAST_IDX_256 = 6'd59;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  index;
        logic        last_key;
        logic [1:0]  size_sel;
    } t_q_entry;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [3:0] key_words(input logic [1:0] sel);
        logic [3:0] nk;
        case (sel)
            KS_128:  nk = 4'd4;
            KS_192:  nk = 4'd6;
            default: nk = 4'd8;
        endcase
        return nk;
    endfunction

    function automatic logic [5:0] last_index(input logic [1:0] sel);
        logic [5:0] idx;
        case (sel)
            KS_128:  idx = LAST_IDX_128;
            KS_192:  idx = LAST_IDX_192;
            default: idx = LAST_IDX_256;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] rot_word(input logic [31:0] w);
        return {w[23:0], w[31:24]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? RCON_POLY : 8'h00);
    endfunction

endpackage

@@ rtl/aeske_front.sv @@
// ----------------------------------------------------------------------------
// AES key expansion front end
// Holds the key size register, counts key words and tags each accepted word
// with its index and whether it completes the key.
// ----------------------------------------------------------------------------
module aeske_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    input  logic               i_accept,
    input  logic [31:0]        i_key_word,
    output aeske_pkg::t_q_entry o_entry
);
    import aeske_pkg::*;

    logic [1:0] r_size_sel;
    logic [2:0] r_count;
    logic [1:0] n_size_sel;
    logic [2:0] n_count;
    logic [3:0] nk;
    logic       is_last;

    assign nk      = key_words(r_size_sel);
    assign is_last = (r_count == 3'(nk - 4'd1));

    always_comb begin
        n_size_sel = r_size_sel;
        n_count    = r_count;
        if (i_cfg_we) begin
            n_size_sel = i_cfg_wdata;
            n_count    = '0;
        end else if (i_accept) begin
            n_count = is_last ? 3'd0 : r_count + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_sel <= KS_128;
            r_count    <= '0;
        end else begin
            r_size_sel <= n_size_sel;
            r_count    <= n_count;
        end
    end

    assign o_entry.word     = i_key_word;
    assign o_entry.index    = {3'd0, r_count};
    assign o_entry.last_key = is_last;
    assign o_entry.size_sel = r_size_sel;

endmodule

@@ rtl/aeske_fifo.sv @@
// ----------------------------------------------------------------------------
// AES key expansion word queue
// Short FIFO of tagged key words between the front end and the expansion unit.
// ----------------------------------------------------------------------------
module aeske_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  aeske_pkg::t_q_entry i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output aeske_pkg::t_q_entry o_entry
);
    import aeske_pkg::*;

    t_q_entry               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/aeske_back.sv @@
// ----------------------------------------------------------------------------
// AES key expansion unit
// Echoes queued key words into the word window and, after the last key word,
// derives the remaining schedule words one per cycle.
// ----------------------------------------------------------------------------
module aeske_back #(
    parameter int MAX_KEY_WORDS = aeske_pkg::MAX_KEY_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  aeske_pkg::t_q_entry i_entry,
    output logic               o_pop,
    output logic               o_active,
    output logic               o_strobe,
    output logic [31:0]        o_round_key_word,
    output logic [5:0]         o_word_index,
    output logic               o_last_word
);
    import aeske_pkg::*;

    localparam int WIN_AW = $clog2(MAX_KEY_WORDS);

    typedef enum logic {
        ST_IDLE,
        ST_GEN
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_sel, n_sel;
    logic [5:0]  r_idx, n_idx;
    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_rcon, n_rcon;
    logic [31:0] r_win [MAX_KEY_WORDS];
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_word, n_out_word;
    logic [5:0]  r_out_index, n_out_index;
    logic        r_out_last, n_out_last;

    logic              shift_en;
    logic [31:0]       shift_word;
    logic [3:0]        nk;
    logic [WIN_AW-1:0] oldest;
    logic [31:0]       temp;
    logic [31:0]       new_word;
    logic              done;

    assign nk     = key_words(r_sel);
    assign oldest = WIN_AW'(MAX_KEY_WORDS - int'(nk));
    assign done   = (r_idx == last_index(r_sel));

    always_comb begin
        if (r_pos == 3'd0) begin
            temp = sub_word(rot_word(r_win[MAX_KEY_WORDS-1])) ^ {r_rcon, 24'd0};
        end else if (nk == 4'd8 && r_pos == 3'd4) begin
            temp = sub_word(r_win[MAX_KEY_WORDS-1]);
        end else begin
            temp = r_win[MAX_KEY_WORDS-1];
        end
        new_word = r_win[oldest] ^ temp;
    end

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_rcon      = r_rcon;
        n_out_valid = 1'b0;
        n_out_word  = r_out_word;
        n_out_index = r_out_index;
        n_out_last  = 1'b0;
        shift_en    = 1'b0;
        shift_word  = new_word;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    shift_en    = 1'b1;
                    shift_word  = i_entry.word;
                    n_out_valid = 1'b1;
                    n_out_word  = i_entry.word;
                    n_out_index = i_entry.index;
                    if (i_entry.last_key) begin
                        n_state = ST_GEN;
                        n_sel   = i_entry.size_sel;
                        n_idx   = {2'd0, key_words(i_entry.size_sel)};
                        n_pos   = '0;
                        n_rcon  = RCON_INIT;
                    end
                end
            end
            ST_GEN: begin
                shift_en    = 1'b1;
                n_out_valid = 1'b1;
                n_out_word  = new_word;
                n_out_index = r_idx;
                n_out_last  = done;
                n_idx       = r_idx + 6'd1;
                n_pos       = (r_pos == 3'(nk - 4'd1)) ? 3'd0 : r_pos + 3'd1;
                if (r_pos == 3'd0) begin
                    n_rcon = xtime(r_rcon);
                end
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int k = 0; k < MAX_KEY_WORDS - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[MAX_KEY_WORDS-1] <= shift_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= KS_128;
            r_idx       <= '0;
            r_pos       <= '0;
            r_rcon      <= RCON_INIT;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_idx       <= n_idx;
            r_pos       <= n_pos;
            r_rcon      <= n_rcon;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
        r_out_word  <= n_out_word;
        r_out_index <= n_out_index;
    end

    assign o_active         = (r_state == ST_GEN);
    assign o_strobe         = r_out_valid;
    assign o_round_key_word = r_out_word;
    assign o_word_index     = r_out_index;
    assign o_last_word      = r_out_last;

    a_gen_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_GEN |=> r_out_valid && r_out_index == $past(r_idx))
        else $error("expansion cycle without output word");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_last |-> r_out_valid && (r_out_index == LAST_IDX_128 ||
        r_out_index == LAST_IDX_192 || r_out_index == LAST_IDX_256))
        else $error("last word flag on wrong index");

    a_last_ends_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_last |-> r_state == ST_IDLE && $past(r_state) == ST_GEN)
        else $error("last word did not end expansion");

    a_no_pop_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_GEN |-> !o_pop)
        else $error("queue popped during expansion");

endmodule

@@ rtl/aes_key_expansion_top.sv @@
// ----------------------------------------------------------------------------
// AES key expansion top level
// Key words go in on start and busy; the expanded schedule comes out one word
// per strobe, with the index and a flag on the last word. The receiver must
// take every strobed word in its cycle, as the output cannot be held off.
// A key word is taken in every cycle while the two-entry queue has room and
// reaches the output through the queue and then the output register of the
// expansion unit. The word that completes the key starts the expansion unit,
// which derives 40, 46 or 52 further words at one per cycle. Key words of the
// next key queue up during expansion and busy rises once the queue is full.
// ----------------------------------------------------------------------------
module aes_key_expansion_top #(
    parameter int MAX_KEY_WORDS = aeske_pkg::MAX_KEY_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_key_word,
    output logic        o_strobe,
    output logic [31:0] o_round_key_word,
    output logic [5:0]  o_word_index,
    output logic        o_last_word
);
    import aeske_pkg::*;

    t_q_entry push_entry;
    t_q_entry pop_entry;
    logic     accept;
    logic     q_full;
    logic     q_empty;
    logic     pop;
    logic     gen_active;

    assign busy   = q_full;
    assign accept = start && !busy;

    aeske_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_key_word  (i_key_word),
        .o_entry     (push_entry)
    );

    aeske_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (pop_entry)
    );

    aeske_back #(
        .MAX_KEY_WORDS (MAX_KEY_WORDS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_entry          (pop_entry),
        .o_pop            (pop),
        .o_active         (gen_active),
        .o_strobe         (o_strobe),
        .o_round_key_word (o_round_key_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    a_busy_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !q_empty && (gen_active || $past(gen_active) || !pop))
        else $error("busy with queue not full");

endmodule

@@ sim/tb_aes_key_expansion_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES key expansion testbench
// Loads 128, 192 and 256 bit keys one word at a time through the start/busy
// handshake and checks every strobed schedule word (value, index, last flag)
// in order against an in-bench key schedule with its own computed S-box.
// Covers the standard key vectors, field extremes, the unused size code, a
// key size change mid-load, and random keys under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_aes_key_expansion_top;
    import aeske_pkg::*;

    localparam logic [1:0] KS_UNUSED    = 2'd3;
    localparam logic [7:0] RCON_FIRST   = 8'h01;
    localparam logic [7:0] GF_POLY      = 8'h1b;
    localparam logic [7:0] AFFINE_CONST = 8'h63;
    localparam int SETTLE_CYCLES        = 8;
    localparam int MAX_ERR_REPORTS      = 10;
    localparam int CYCLE_LIMIT          = 200000;

    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  index;
        logic        last;
    } t_sched_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_wdata;
    logic        start;
    logic        busy;
    logic [31:0] i_key_word;
    logic        o_strobe;
    logic [31:0] o_round_key_word;
    logic [5:0]  o_word_index;
    logic        o_last_word;

    // schedule state mirrored by the bench
    logic [7:0]  sbox_lut [0:255];
    logic [1:0]  size_sel_q   = KS_128;
    logic [31:0] sched_window [0:7];
    int          words_loaded = 0;
    logic [7:0]  rcon_next    = RCON_FIRST;
    t_sched_word expected_words [$];

    int error_count = 0;
    int cycle_count = 0;

    aes_key_expansion_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .start            (start),
        .busy             (busy),
        .i_key_word       (i_key_word),
        .o_strobe         (o_strobe),
        .o_round_key_word (o_round_key_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        int         k;
        p = 8'h00;
        for (k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
        end
        return p;
    endfunction

    // S-box from the GF(2^8) inverse and the affine map
    task automatic build_sbox;
        logic [7:0] inv, rot, s;
        int         b, k;
        for (b = 0; b < 256; b++) begin
            inv = 8'h01;
            for (k = 0; k < 254; k++) inv = gf_mul(inv, 8'(b));
            s   = inv;
            rot = inv;
            for (k = 0; k < 4; k++) begin
                rot = {rot[6:0], rot[7]};
                s  ^= rot;
            end
            sbox_lut[b] = s ^ AFFINE_CONST;
        end
    endtask

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
    endfunction

    function automatic int key_len_words(input logic [1:0] sel);
        if (sel == KS_128) return 4;
        if (sel == KS_192) return 6;
        return 8;
    endfunction

    task automatic push_expected(input logic [31:0] w, input int idx, input logic last);
        t_sched_word e;
        e.word  = w;
        e.index = 6'(idx);
        e.last  = last;
        expected_words.push_back(e);
    endtask

    task automatic expand_key_word(input logic [31:0] word);
        int          nk, total, pos, i, j;
        logic [31:0] t, w;
        nk    = key_len_words(size_sel_q);
        total = (nk + 7) * 4;
        if (words_loaded >= nk) words_loaded = 0;
        sched_window[words_loaded] = word;
        push_expected(word, words_loaded, 1'b0);
        words_loaded++;
        if (words_loaded < nk) return;
        pos = 0;
        for (i = nk; i < total; i++) begin
            t = sched_window[nk - 1];
            if (pos == 0) begin
                t = subst_word({t[23:0], t[31:24]}) ^ {rcon_next, 24'h0};
                rcon_next = {rcon_next[6:0], 1'b0} ^ (rcon_next[7] ? GF_POLY : 8'h00);
            end else if (nk > 6 && pos == 4) begin
                t = subst_word(t);
            end
            w = sched_window[0] ^ t;
            for (j = 0; j + 1 < nk; j++) sched_window[j] = sched_window[j + 1];
            sched_window[nk - 1] = w;
            push_expected(w, i, i == total - 1);
            pos = (pos + 1 == nk) ? 0 : pos + 1;
        end
        words_loaded = 0;
        rcon_next    = RCON_FIRST;
    endtask

    always @(posedge i_clk) begin
        t_sched_word e;
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                if (error_count < MAX_ERR_REPORTS)
                    $display("unexpected word %h index %0d last %0b",
                             o_round_key_word, o_word_index, o_last_word);
                error_count++;
            end else begin
                e = expected_words.pop_front();
                if (o_round_key_word !== e.word || o_word_index !== e.index ||
                    o_last_word !== e.last) begin
                    if (error_count < MAX_ERR_REPORTS)
                        $display("mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                                 e.word, e.index, e.last,
                                 o_round_key_word, o_word_index, o_last_word);
                    error_count++;
                end
            end
        end
    end

    task automatic send_key_word(input logic [31:0] word, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_key_word <= word;
        do @(posedge i_clk); while (busy);
        expand_key_word(word);
    endtask

    task automatic drain_schedule;
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic set_key_size(input logic [1:0] sel);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= sel;
        @(posedge i_clk);
        size_sel_q   = sel;
        words_loaded = 0;
        rcon_next    = RCON_FIRST;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_key(input logic [1:0] sel, input logic [31:0] words [8]);
        int k;
        drain_schedule();
        set_key_size(sel);
        for (k = 0; k < key_len_words(sel); k++) send_key_word(words[k], 0);
    endtask

    task automatic test_key128_vector;
        send_key(KS_128, '{32'h2b7e1516, 32'h28aed2a6, 32'habf71588, 32'h09cf4f3c,
                           32'h0, 32'h0, 32'h0, 32'h0});
    endtask

    task automatic test_key192_vector;
        send_key(KS_192, '{32'h8e73b0f7, 32'hda0e6452, 32'hc810f32b, 32'h809079e5,
                           32'h62f8ead2, 32'h522c6b7b, 32'h0, 32'h0});
    endtask

    task automatic test_key256_vector;
        send_key(KS_256, '{32'h603deb10, 32'h15ca71be, 32'h2b73aef0, 32'h857d7781,
                           32'h1f352c07, 32'h3b6108d7, 32'h2d9810a3, 32'h0914dff4});
    endtask

    // partial 192-bit key, then a size change abandons it
    task automatic test_size_change_mid_load;
        drain_schedule();
        set_key_size(KS_192);
        send_key_word(32'hdeadbeef, 0);
        send_key_word(32'h01234567, 0);
    endtask

    // unused size code behaves as 256-bit; words at the field extremes
    task automatic test_unused_size_extremes;
        send_key(KS_UNUSED, '{32'h00000000, 32'hffffffff, 32'h00000000, 32'hffffffff,
                              32'h80000000, 32'h00000001, 32'h7fffffff, 32'hfffffffe});
    endtask

    task automatic test_random_keys(input int idle_pct, input int n_words,
                                    input logic [1:0] first_sel);
        int sent, nk, cut, k;
        drain_schedule();
        set_key_size(first_sel);
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(7) == 0) begin
                drain_schedule();
                set_key_size(2'($urandom_range(3)));
            end
            nk  = key_len_words(size_sel_q);
            cut = ($urandom_range(9) == 0) ? $urandom_range(nk - 1, 1) : nk;
            for (k = 0; k < cut; k++) begin
                send_key_word($urandom, idle_pct);
                sent++;
            end
            if (cut < nk) begin
                drain_schedule();
                set_key_size(2'($urandom_range(3)));
            end else if ($urandom_range(9) == 0) begin
                // pause the sender before the next key, which may let the expansion run out
                @(negedge i_clk);
                start <= 1'b0;
                repeat ($urandom_range(70, 1)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = KS_128;
        start       = 1'b0;
        i_key_word  = 32'h0;
        build_sbox();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_key128_vector();
        test_key192_vector();
        test_key256_vector();
        test_size_change_mid_load();
        test_unused_size_extremes();
        test_random_keys(0, 100, KS_256);
        test_random_keys(49, 100, KS_128);
        test_random_keys(21, 100, KS_192);

        drain_schedule();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
